// ===== sv/vector_rotate_by_angle_core_macros.svh =====
// ----------------------------------------------------------------------------
// Vector rotation core assertion macros
// Shared concurrent checks; they expect clk and rst in the using scope.
// ----------------------------------------------------------------------------
`ifndef VECTOR_ROTATE_BY_ANGLE_CORE_MACROS_SVH
`define VECTOR_ROTATE_BY_ANGLE_CORE_MACROS_SVH

// Same-cycle implication, checked outside of reset.
`define VRBA_ASSERT_IMP(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("vrba: same-cycle check failed");

// Next-cycle implication, checked outside of reset.
`define VRBA_ASSERT_NEXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("vrba: next-cycle check failed");

`endif

// ===== sv/vrba_pkg.sv =====
// ----------------------------------------------------------------------------
// Vector rotation package
// Widths, angle constants, arctangent table and the pipeline payload type.
// ----------------------------------------------------------------------------
package vrba_pkg;

  // Field widths.
  localparam int XW = 32;   // Q16.16 coordinates
  localparam int AW = 20;   // Q3.16 angle
  localparam int CW = 33;   // CORDIC x/y in Q.30 with headroom
  localparam int ZW = 34;   // residual angle in Q.30
  localparam int RW = 36;   // angle reduction arithmetic
  localparam int PW = XW + CW;      // one product
  localparam int SW = PW + 1;       // sum of two products
  localparam int QW = SW - 30;      // sum after dropping the fraction
  localparam int ATAN_ENTRIES = 24;

  // Angle constants in Q.30, widened for reduction.
  localparam logic signed [RW-1:0] Q30_PI      = 36'sd3373259426;
  localparam logic signed [RW-1:0] Q30_HALF_PI = 36'sd1686629713;
  localparam logic signed [RW-1:0] Q30_PI2     = 36'sd6746518852;
  localparam logic signed [RW-1:0] Q30_PI3     = 36'sd10119778278;

  // Fold thresholds around the wrapped ranges.
  localparam logic signed [RW-1:0] THR_2PI_HI = Q30_PI2 + Q30_HALF_PI;
  localparam logic signed [RW-1:0] THR_2PI_LO = Q30_PI2 - Q30_HALF_PI;

  // Residual angle bound after folding, at residual width.
  localparam logic signed [ZW-1:0] Z_HALF_PI = 34'sd1686629713;

  // CORDIC start value: limit gain in Q.30.
  localparam logic signed [CW-1:0] CORDIC_GAIN = 33'sd652032874;

  // Rounding offset for the Q.30 to Q16.16 conversion.
  localparam logic signed [SW-1:0] ROUND_HALF = SW'(64'sd536870912);

  // Saturation limits at the rounded width.
  localparam logic signed [QW-1:0] SAT_MAX = QW'(64'sd2147483647);
  localparam logic signed [QW-1:0] SAT_MIN = QW'(-64'sd2147483648);

  // atan(2^-i) in Q.30, truncated.
  localparam logic [29:0] ATAN_TBL [0:ATAN_ENTRIES-1] = '{
    30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158,
    30'd67021686,  30'd33543515,  30'd16775850,  30'd8388437,
    30'd4194282,   30'd2097149,   30'd1048575,   30'd524287,
    30'd262143,    30'd131071,    30'd65535,     30'd32767,
    30'd16383,     30'd8191,      30'd4095,      30'd2047,
    30'd1023,      30'd511,       30'd255,       30'd127
  };

  // Payload carried through the reduction and CORDIC stages.
  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [ZW-1:0] z;
    logic                 neg;
  } vrba_rot_t;

endpackage

// ===== sv/vector_rotate_by_angle_core.sv =====
// Vector rotation core: rotates a Q16.16 point counterclockwise by an angle.
// Input items arrive on s_tvalid/s_tready/s_tdata and carry x_in, y_in
// (signed Q16.16) and angle (signed Q3.16 radians). Result items leave on
// m_tvalid/m_tready/m_tdata and carry x_out and y_out (signed Q16.16,
// rounded half up and saturated).
// Throughput is one item per cycle while the receiver takes results. The
// registered steps are the angle reduction, one per CORDIC micro-rotation,
// then the products, their sums and the rounding with saturation.
// The depth is set by the chain of CORDIC stages, one per iteration.
// Every stage has its own valid bit and takes a new item whenever it is
// empty or its successor takes its item, so empty stages fill up while the
// receiver stalls and s_tready falls only when the whole pipeline is full.
// A stall holds every item in place; nothing is dropped or repeated.
// Reset clears all valid bits; no item is in flight afterwards and
// s_tready is high in the first cycle after reset.
`include "vector_rotate_by_angle_core_macros.svh"

// ----------------------------------------------------------------------------
// Vector rotation core
// Angle reduction, CORDIC sine/cosine pipeline and rotation products.
// ----------------------------------------------------------------------------
module vector_rotate_by_angle_core #(
  parameter int ITERATIONS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [87:0] s_tdata,   // x_in [31:0], y_in [63:32], angle [83:64], zero [87:84]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata    // x_out [31:0], y_out [63:32]
);
  import vrba_pkg::*;

  logic      vld [0:ITERATIONS];
  logic      rdy [0:ITERATIONS+1];
  vrba_rot_t rot [0:ITERATIONS];

  logic [XW-1:0] x_res;
  logic [XW-1:0] y_res;

  logic          z_in_range;
  logic          cordic_guard_ok;

  // Angle reduction and CORDIC seed.
  vrba_reduce u_reduce (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (rdy[0]),
    .x_in      (s_tdata[XW-1:0]),
    .y_in      (s_tdata[2*XW-1:XW]),
    .angle     (s_tdata[2*XW+AW-1:2*XW]),
    .out_valid (vld[0]),
    .out_ready (rdy[1]),
    .out_rot   (rot[0])
  );

  assign s_tready = rdy[0];

  // One stage per CORDIC iteration.
  for (genvar i = 0; i < ITERATIONS; i++) begin : g_cordic
    vrba_cordic_stage #(
      .IDX (i)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (vld[i]),
      .in_ready  (rdy[i+1]),
      .in_rot    (rot[i]),
      .out_valid (vld[i+1]),
      .out_ready (rdy[i+2]),
      .out_rot   (rot[i+1])
    );
  end

  // Products, rounding and saturation.
  vrba_mult u_mult (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld[ITERATIONS]),
    .in_ready  (rdy[ITERATIONS+1]),
    .in_rot    (rot[ITERATIONS]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .x_out     (x_res),
    .y_out     (y_res)
  );

  assign m_tdata = {y_res, x_res};

  // Conditions watched by the checks below.
  assign z_in_range = (rot[0].z <= Z_HALF_PI) && (rot[0].z >= -Z_HALF_PI);
  assign cordic_guard_ok =
    (rot[ITERATIONS].cx[CW-1] == rot[ITERATIONS].cx[CW-2]) &&
    (rot[ITERATIONS].cy[CW-1] == rot[ITERATIONS].cy[CW-2]);

  // The reduced angle always lies within plus or minus pi/2.
  `VRBA_ASSERT_IMP(a_reduced_range, vld[0], z_in_range)
  // The CORDIC vector never grows into its top guard bit.
  `VRBA_ASSERT_IMP(a_cordic_headroom, vld[ITERATIONS], cordic_guard_ok)
  // Input is refused only while the first stage holds an item.
  `VRBA_ASSERT_IMP(a_busy_only_when_full, !s_tready, vld[0])
  // A stalled first stage keeps its item.
  `VRBA_ASSERT_NEXT(a_first_stage_holds, vld[0] && !rdy[1], vld[0])

endmodule

// ===== sv/vrba_reduce.sv =====
// ----------------------------------------------------------------------------
// Angle reduction stage
// Wraps the angle into [-pi, pi], folds it into [-pi/2, pi/2] and seeds CORDIC.
// ----------------------------------------------------------------------------
module vrba_reduce (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [vrba_pkg::XW-1:0]    x_in,
  input  logic [vrba_pkg::XW-1:0]    y_in,
  input  logic [vrba_pkg::AW-1:0]    angle,
  output logic                       out_valid,
  input  logic                       out_ready,
  output vrba_pkg::vrba_rot_t        out_rot
);
  import vrba_pkg::*;

  logic signed [RW-1:0] z0;
  logic signed [RW-1:0] offset;
  logic signed [RW-1:0] z_red;
  logic                 fold;
  vrba_rot_t            rot_next;

  // Angle in Q.30 at reduction width.
  assign z0 = {{(RW-AW-14){angle[AW-1]}}, angle, 14'b0};

  // Pick the multiple of pi to remove; all compares run against constants.
  always_comb begin
    offset = '0;
    fold   = 1'b0;
    priority if (z0 > Q30_PI) begin
      priority if (z0 > THR_2PI_HI) begin
        offset = Q30_PI3;
        fold   = 1'b1;
      end else if (z0 < THR_2PI_LO) begin
        offset = Q30_PI;
        fold   = 1'b1;
      end else begin
        offset = Q30_PI2;
      end
    end else if (z0 < -Q30_PI) begin
      priority if (z0 < -THR_2PI_HI) begin
        offset = -Q30_PI3;
        fold   = 1'b1;
      end else if (z0 > -THR_2PI_LO) begin
        offset = -Q30_PI;
        fold   = 1'b1;
      end else begin
        offset = -Q30_PI2;
      end
    end else if (z0 > Q30_HALF_PI) begin
      offset = Q30_PI;
      fold   = 1'b1;
    end else if (z0 < -Q30_HALF_PI) begin
      offset = -Q30_PI;
      fold   = 1'b1;
    end else begin
      offset = '0;
    end
  end

  assign z_red = z0 - offset;

  // Seed the CORDIC vector at (K, 0).
  always_comb begin
    rot_next.x   = x_in;
    rot_next.y   = y_in;
    rot_next.cx  = CORDIC_GAIN;
    rot_next.cy  = '0;
    rot_next.z   = z_red[ZW-1:0];
    rot_next.neg = fold;
  end

  assign in_ready = ~out_valid | out_ready;

  // Stage register with its valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_rot <= rot_next;
    end
  end

endmodule

// ===== sv/vrba_cordic_stage.sv =====
// ----------------------------------------------------------------------------
// CORDIC rotation stage
// One shift-add micro-rotation toward zero residual angle.
// ----------------------------------------------------------------------------
module vrba_cordic_stage #(
  parameter int IDX = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  vrba_pkg::vrba_rot_t in_rot,
  output logic                out_valid,
  input  logic                out_ready,
  output vrba_pkg::vrba_rot_t out_rot
);
  import vrba_pkg::*;

  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic signed [ZW-1:0] atan_z;
  vrba_rot_t            rot_next;

  // Arithmetic shifts round toward minus infinity.
  assign dx     = in_rot.cy >>> IDX;
  assign dy     = in_rot.cx >>> IDX;
  assign atan_z = {{(ZW-30){1'b0}}, ATAN_TBL[IDX]};

  // Rotate by the sign of the residual angle.
  always_comb begin
    rot_next = in_rot;
    if (!in_rot.z[ZW-1]) begin
      rot_next.cx = in_rot.cx - dx;
      rot_next.cy = in_rot.cy + dy;
      rot_next.z  = in_rot.z - atan_z;
    end else begin
      rot_next.cx = in_rot.cx + dx;
      rot_next.cy = in_rot.cy - dy;
      rot_next.z  = in_rot.z + atan_z;
    end
  end

  assign in_ready = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_rot <= rot_next;
    end
  end

endmodule

// ===== sv/vrba_mult.sv =====
// ----------------------------------------------------------------------------
// Rotation product stage
// Multiplies the point by cos/sin, sums, rounds to Q16.16 and saturates.
// ----------------------------------------------------------------------------
module vrba_mult (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  vrba_pkg::vrba_rot_t      in_rot,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [vrba_pkg::XW-1:0]  x_out,
  output logic [vrba_pkg::XW-1:0]  y_out
);
  import vrba_pkg::*;

  // Stage valid bits and readiness.
  logic va, vb, vc;
  logic ra, rb, rc;

  // Product stage.
  logic signed [PW-1:0] p_xc, p_ys, p_xs, p_yc;
  logic                 neg_a;

  // Sum stage.
  logic signed [SW-1:0] s_x, s_y;
  logic signed [SW-1:0] s_x_next, s_y_next;
  logic signed [SW-1:0] e_xc, e_ys, e_xs, e_yc;

  // Rounding stage.
  logic signed [SW-1:0] t_x, t_y;
  logic signed [QW-1:0] q_x, q_y;
  logic [XW-1:0]        x_sat, y_sat;

  assign rc       = ~vc | out_ready;
  assign rb       = ~vb | rc;
  assign ra       = ~va | rb;
  assign in_ready = ra;
  assign out_valid = vc;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      if (ra) va <= in_valid;
      if (rb) vb <= va;
      if (rc) vc <= vb;
    end
  end

  // Four products of the point with cos and sin.
  always_ff @(posedge clk) begin
    if (ra && in_valid) begin
      p_xc  <= in_rot.x * in_rot.cx;
      p_ys  <= in_rot.y * in_rot.cy;
      p_xs  <= in_rot.x * in_rot.cy;
      p_yc  <= in_rot.y * in_rot.cx;
      neg_a <= in_rot.neg;
    end
  end

  // Sums; a folded angle negates cos and sin, so the sums flip sign.
  assign e_xc = SW'(p_xc);
  assign e_ys = SW'(p_ys);
  assign e_xs = SW'(p_xs);
  assign e_yc = SW'(p_yc);

  always_comb begin
    if (neg_a) begin
      s_x_next = e_ys - e_xc;
      s_y_next = -e_xs - e_yc;
    end else begin
      s_x_next = e_xc - e_ys;
      s_y_next = e_xs + e_yc;
    end
  end

  always_ff @(posedge clk) begin
    if (rb && va) begin
      s_x <= s_x_next;
      s_y <= s_y_next;
    end
  end

  // Round half up to Q16.16, then clamp to the 32-bit range.
  assign t_x = s_x + ROUND_HALF;
  assign t_y = s_y + ROUND_HALF;
  assign q_x = QW'(t_x >>> 30);
  assign q_y = QW'(t_y >>> 30);

  always_comb begin
    priority if (q_x > SAT_MAX) begin
      x_sat = SAT_MAX[XW-1:0];
    end else if (q_x < SAT_MIN) begin
      x_sat = SAT_MIN[XW-1:0];
    end else begin
      x_sat = q_x[XW-1:0];
    end
    priority if (q_y > SAT_MAX) begin
      y_sat = SAT_MAX[XW-1:0];
    end else if (q_y < SAT_MIN) begin
      y_sat = SAT_MIN[XW-1:0];
    end else begin
      y_sat = q_y[XW-1:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rc && vb) begin
      x_out <= x_sat;
      y_out <= y_sat;
    end
  end

endmodule
